/* src/running_median_of_five_macros.svh */
// ----------------------------------------------------------------------------
// running median assertion macros
// concurrent checks that can be compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_OF_FIVE_MACROS_SVH
`define RUNNING_MEDIAN_OF_FIVE_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define RMO5_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("running median check failed");

// antecedent implies consequent in the next cycle
`define RMO5_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("running median check failed");

`else

`define RMO5_ASSERT_SAME(label, clk, rst, ante, cons)
`define RMO5_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/rmo5_pkg.sv */
// ----------------------------------------------------------------------------
// rmo5_pkg
// shared constants and types of the running median block
// ----------------------------------------------------------------------------
`default_nettype none

package rmo5_pkg;

   // window geometry
   localparam int WINDOW = 5;
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int IN_W     = 32;
   localparam int MEDIAN_W = 17;
   localparam int COUNT_W  = 3;

   // constants
   localparam logic [SAMPLE_W-1:0] VALID_RESET  = 16'd60000;
   localparam logic [SAMPLE_W-1:0] CLAMP_TOP    = 16'hFFFF;
   localparam logic [MEDIAN_W-1:0] MEDIAN_EMPTY = '1;

   // commands
   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // sequencer to rank unit control
   typedef struct packed {
      logic load_cand;
      logic step;
   } rank_ctl_type;

endpackage

`default_nettype wire

/* src/rmo5_window.sv */
// ----------------------------------------------------------------------------
// rmo5_window
// circular sample store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rmo5_window
   import rmo5_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [IDX_W-1:0]    wr_addr,
   input  wire logic [SAMPLE_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]    rd_addr,
   output logic      [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [WINDOW];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/rmo5_rank.sv */
// ----------------------------------------------------------------------------
// rmo5_rank
// shared comparator and rank counter for one candidate entry
// ----------------------------------------------------------------------------
`default_nettype none

module rmo5_rank
   import rmo5_pkg::*;
(
   input  wire logic                clock,
   input  wire rank_ctl_type        ctl,
   input  wire logic [SAMPLE_W-1:0] rd_data,
   input  wire logic [IDX_W-1:0]    cand_idx,
   input  wire logic [IDX_W-1:0]    cmp_idx,
   output logic      [SAMPLE_W-1:0] cand,
   output logic      [CNT_W-1:0]    rank_next
);

   logic [SAMPLE_W-1:0] cand_ff;
   logic [CNT_W-1:0]    rank_ff;
   logic                ahead;

   // entry sorts ahead of the candidate; ties broken by slot so ranks are unique
   assign ahead = (rd_data < cand_ff) || ((rd_data == cand_ff) && (cmp_idx < cand_idx));

   assign rank_next = rank_ff + CNT_W'(ahead);

   // candidate and running rank
   always_ff @(posedge clock) begin
      if (ctl.load_cand) begin
         cand_ff <= rd_data;
         rank_ff <= '0;
      end else if (ctl.step) begin
         rank_ff <= rank_next;
      end
   end

   assign cand = cand_ff;

endmodule

`default_nettype wire

/* src/running_median_of_five.sv */
// ----------------------------------------------------------------------------
// running_median_of_five
// running median over the most recent samples with a shared comparator
// ----------------------------------------------------------------------------
// Every request item gives one response item with the current median, count
// and whether its sample was taken. A clear, or a sample above the threshold
// in csr_max_valid_sample, skips the median search. A taken sample is written
// to the window and the median is found by ranking the n held entries one at
// a time against all others on a single comparator, fed by a store with one
// registered read port. The request side is busy during that walk; a finished
// response waits in its output register while the next request is taken.
`default_nettype none

`include "running_median_of_five_macros.svh"

module running_median_of_five
   import rmo5_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_cmd,
   input  wire logic [IN_W-1:0]     req_sample_value,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [MEDIAN_W-1:0] rsp_median_value,
   output logic      [COUNT_W-1:0]  rsp_sample_count,
   output logic                     rsp_sample_taken,
   // configuration
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [SAMPLE_W-1:0] csr_max_valid_sample
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RDC  = 3'd1;
   localparam logic [2:0] ST_CAPC = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]          state_ff,    state_in;
   logic [IDX_W-1:0]    slot_ff,     slot_in;
   logic [CNT_W-1:0]    count_ff,    count_in;
   logic [MEDIAN_W-1:0] median_ff,   median_in;
   logic                taken_ff,    taken_in;
   logic [IDX_W-1:0]    cand_idx_ff, cand_idx_in;
   logic [IDX_W-1:0]    cmp_idx_ff,  cmp_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MEDIAN_W-1:0] rsp_median_ff, rsp_median_in;
   logic [COUNT_W-1:0]  rsp_count_ff,  rsp_count_in;
   logic                rsp_taken_ff,  rsp_taken_in;
   logic [SAMPLE_W-1:0] max_valid_ff;

   logic                req_fire;
   logic                sample_ok;
   logic [SAMPLE_W-1:0] sample_clamped;
   logic                wr_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic [SAMPLE_W-1:0] cand;
   logic [CNT_W-1:0]    rank_next;
   logic                cmp_last;
   logic                out_free;
   rank_ctl_type        rank_ctl;

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // threshold test and clamp
   assign sample_ok      = (req_sample_value <= IN_W'(max_valid_ff));
   assign sample_clamped = (req_sample_value[IN_W-1:SAMPLE_W] != '0) ? CLAMP_TOP
                                                                      : req_sample_value[SAMPLE_W-1:0];

   // last compare of the current candidate
   assign cmp_last = (cmp_idx_ff == IDX_W'(count_ff - CNT_W'(1)));

   rmo5_window u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (sample_clamped),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rmo5_rank u_rank (
      .clock     (clock),
      .ctl       (rank_ctl),
      .rd_data   (rd_data),
      .cand_idx  (cand_idx_ff),
      .cmp_idx   (cmp_idx_ff),
      .cand      (cand),
      .rank_next (rank_next)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      count_in      = count_ff;
      median_in     = median_ff;
      taken_in      = taken_ff;
      cand_idx_in   = cand_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_median_in = rsp_median_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_taken_in  = rsp_taken_ff;
      wr_en         = 1'b0;
      rd_addr       = '0;
      rank_ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_cmd == CMD_CLEAR) begin
                  slot_in   = '0;
                  count_in  = '0;
                  median_in = MEDIAN_EMPTY;
                  taken_in  = 1'b0;
                  state_in  = ST_DONE;
               end else if (sample_ok) begin
                  wr_en       = 1'b1;
                  slot_in     = (slot_ff == IDX_W'(WINDOW - 1)) ? '0 : slot_ff + IDX_W'(1);
                  count_in    = (count_ff == CNT_W'(WINDOW)) ? count_ff : count_ff + CNT_W'(1);
                  taken_in    = 1'b1;
                  cand_idx_in = '0;
                  state_in    = ST_RDC;
               end else begin
                  taken_in = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_RDC: begin
            rd_addr  = cand_idx_ff;
            state_in = ST_CAPC;
         end
         ST_CAPC: begin
            rank_ctl.load_cand = 1'b1;
            rd_addr            = '0;
            cmp_idx_in         = '0;
            state_in           = ST_CMP;
         end
         ST_CMP: begin
            rank_ctl.step = 1'b1;
            if (cmp_last) begin
               if (rank_next == (count_ff >> 1)) begin
                  median_in = {1'b0, cand};
                  state_in  = ST_DONE;
               end else begin
                  cand_idx_in = cand_idx_ff + IDX_W'(1);
                  state_in    = ST_RDC;
               end
            end else begin
               cmp_idx_in = cmp_idx_ff + IDX_W'(1);
               rd_addr    = cmp_idx_ff + IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = median_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_taken_in  = taken_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         count_ff     <= '0;
         median_ff    <= MEDIAN_EMPTY;
         taken_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_valid_ff <= VALID_RESET;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         median_ff    <= median_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_valid_ff <= csr_max_valid_sample;
         end
      end
   end

   // walk indices and response payload
   always_ff @(posedge clock) begin
      cand_idx_ff   <= cand_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_median_ff <= rsp_median_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_taken_ff  <= rsp_taken_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = $signed(rsp_median_ff);
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_sample_taken = rsp_taken_ff;

   // checks
   `RMO5_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_ready)
   `RMO5_ASSERT_SAME(a_empty_median, clock, reset, rsp_valid && (rsp_sample_count == '0), rsp_median_ff == MEDIAN_EMPTY)
   `RMO5_ASSERT_SAME(a_taken_has_count, clock, reset, rsp_valid && rsp_sample_taken, rsp_sample_count != '0)
   `RMO5_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(WINDOW))

endmodule

`default_nettype wire

/* test/running_median_of_five_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_of_five_test
// self-checking bench for the running median filter
// ----------------------------------------------------------------------------
// Sends push and clear items through the request channel and predicts every
// response item from an internal copy of the window, count, median and
// rejection threshold. A directed pass covers the threshold edges, wrap of
// the window, the even-count upper median and clears. Random traffic then
// runs under three idling patterns and several threshold settings.
// ----------------------------------------------------------------------------

module running_median_of_five_test;
   import rmo5_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SHOWN_ERRORS = 10;

   typedef struct {
      logic signed [MEDIAN_W-1:0] median;
      logic [COUNT_W-1:0] count;
      logic taken;
   } median_result_type;

   // block ports
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = CMD_PUSH;
   logic [IN_W-1:0] req_sample_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [MEDIAN_W-1:0] rsp_median_value;
   logic [COUNT_W-1:0] rsp_sample_count;
   logic rsp_sample_taken;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [SAMPLE_W-1:0] csr_max_valid_sample = '0;

   // predicted filter state
   logic [SAMPLE_W-1:0] held_samples [WINDOW];
   int held_count = 0;
   int next_slot = 0;
   logic signed [MEDIAN_W-1:0] current_median = MEDIAN_EMPTY;
   logic [SAMPLE_W-1:0] sample_limit = VALID_RESET;

   median_result_type expected_medians [$];
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   running_median_of_five uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_sample_value(req_sample_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_median_value(rsp_median_value),
      .rsp_sample_count(rsp_sample_count),
      .rsp_sample_taken(rsp_sample_taken),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_max_valid_sample(csr_max_valid_sample)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("running_median_of_five_test NOT OK");
         $finish;
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // upper median of the held samples, insertion sorted
   function automatic logic signed [MEDIAN_W-1:0] window_median();
      logic [SAMPLE_W-1:0] sorted [WINDOW];
      logic [SAMPLE_W-1:0] key;
      int j;
      if (held_count == 0)
         return MEDIAN_EMPTY;
      for (int i = 0; i < held_count; i++)
         sorted[i] = held_samples[i];
      for (int i = 1; i < held_count; i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      return $signed({1'b0, sorted[held_count/2]});
   endfunction

   // apply one accepted item to the predicted state and queue its result
   function automatic void track_item(input logic cmd, input logic [IN_W-1:0] value);
      median_result_type result;
      result.taken = 1'b0;
      if (cmd == CMD_CLEAR) begin
         next_slot = 0;
         held_count = 0;
         current_median = MEDIAN_EMPTY;
      end else if (value <= {16'd0, sample_limit}) begin
         held_samples[next_slot] = (value > {16'd0, CLAMP_TOP}) ? CLAMP_TOP : value[SAMPLE_W-1:0];
         next_slot = (next_slot + 1) % WINDOW;
         if (held_count < WINDOW)
            held_count++;
         current_median = window_median();
         result.taken = 1'b1;
      end
      result.median = current_median;
      result.count = held_count[COUNT_W-1:0];
      expected_medians.push_back(result);
   endfunction

   // watch all three channels and check each response item
   always @(posedge clock) begin
      median_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready)
            sample_limit = csr_max_valid_sample;
         if (req_valid && req_ready)
            track_item(req_cmd, req_sample_value);
         if (rsp_valid && rsp_ready) begin
            if (expected_medians.size() == 0) begin
               error_count++;
               if (error_count <= SHOWN_ERRORS)
                  $display("unexpected item: median %0d count %0d taken %0b",
                     rsp_median_value, rsp_sample_count, rsp_sample_taken);
            end else begin
               want = expected_medians.pop_front();
               if (rsp_median_value !== want.median || rsp_sample_count !== want.count ||
                     rsp_sample_taken !== want.taken) begin
                  error_count++;
                  if (error_count <= SHOWN_ERRORS)
                     $display("mismatch: median %0d/%0d count %0d/%0d taken %0b/%0b (exp/got)",
                        want.median, rsp_median_value, want.count, rsp_sample_count,
                        want.taken, rsp_sample_taken);
               end
            end
         end
      end
   end

   // send one item, with random idle cycles ahead of it
   task automatic send_item(input logic cmd, input logic [IN_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_sample_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off the sender until every outstanding result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_medians.size() != 0)
         @(posedge clock);
   endtask

   // write the rejection threshold while the block is idle
   task automatic write_limit(input logic [SAMPLE_W-1:0] value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_max_valid_sample <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // threshold edges, window wrap, even count, clears
   task automatic test_directed_cases();
      write_limit(VALID_RESET);
      send_item(CMD_PUSH, 32'd100);
      send_item(CMD_PUSH, 32'd60001);
      send_item(CMD_PUSH, 32'd60000);
      send_item(CMD_PUSH, 32'hFFFF_FFFF);
      send_item(CMD_PUSH, 32'd0);
      send_item(CMD_PUSH, 32'd7);
      send_item(CMD_PUSH, 32'd50);
      send_item(CMD_PUSH, 32'd3);
      send_item(CMD_PUSH, 32'd3);
      send_item(CMD_CLEAR, 32'hA5A5_A5A5);
      send_item(CMD_CLEAR, 32'd0);
      send_item(CMD_PUSH, 32'd65535);
      send_item(CMD_PUSH, 32'd1);
      write_limit(16'hFFFF);
      send_item(CMD_PUSH, 32'd65535);
      send_item(CMD_PUSH, 32'd65536);
      send_item(CMD_PUSH, 32'h8000_0000);
      send_item(CMD_PUSH, 32'd65535);
      write_limit(16'd0);
      send_item(CMD_PUSH, 32'd0);
      send_item(CMD_PUSH, 32'd1);
      send_item(CMD_CLEAR, 32'h5A5A_5A5A);
      send_item(CMD_PUSH, 32'd0);
      wait_for_results();
   endtask

   // sample value biased toward the threshold and toward repeats
   function automatic logic [IN_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] limit);
      case ($urandom_range(9))
         0: return $urandom;
         1: return {16'd0, limit} + $urandom_range(1, 3);
         2: return {16'd0, limit};
         3: return $urandom_range(7);
         default: return $urandom_range(int'(limit), 0);
      endcase
   endfunction

   // random pushes with rare clears under one idling pattern
   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
         input logic [SAMPLE_W-1:0] limit);
      write_limit(limit);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(199) == 0)
            wait_for_results();
         if (n == count / 2)
            write_limit(SAMPLE_W'($urandom_range(1000, 65534)));
         if ($urandom_range(99) < 3)
            send_item(CMD_CLEAR, $urandom);
         else
            send_item(CMD_PUSH, pick_sample(sample_limit));
      end
      wait_for_results();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic(600, 31, 78, 16'd300);
      test_random_traffic(600, 78, 31, 16'hFFFF);
      test_random_traffic(600, 0, 0, VALID_RESET);
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_medians.size() == 0)
         $display("running_median_of_five_test OK");
      else
         $display("running_median_of_five_test NOT OK");
      $finish;
   end

endmodule
